>>> hdl/ttsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttsd_pkg
// Shared types and constants of the tiled texture stream decoder.
// ----------------------------------------------------------------------------
package ttsd_pkg;

  localparam int unsigned DATA_W          = 16;
  localparam int unsigned COORD_W         = 10;
  localparam int unsigned COLOR_W         = 8;
  localparam int unsigned CFG_W           = 11;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned MAX_DIM_DEFAULT = 1024;
  localparam int unsigned TILE_SIDE       = 4;
  localparam int unsigned TILE_BITS       = 2;
  localparam int unsigned TEXELS_PER_TILE = TILE_SIDE * TILE_SIDE;
  localparam int unsigned TEXEL_W         = 2 * TILE_BITS;
  localparam int unsigned WORD_POS_W      = TEXEL_W + 1;
  localparam int unsigned OUT_DATA_W      = 56;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  typedef enum logic [1:0] {
    FMT_RGB565 = 2'd0,
    FMT_RGB5A3 = 2'd1,
    FMT_RGBA8  = 2'd2
  } fmt_e;

  // per-word decode information handed to the colour stage
  typedef struct packed {
    logic               emit;
    logic               planes;
    logic               fmt_5a3;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } pix_info_t;

  // access to the alpha-red store
  typedef struct packed {
    logic               we;
    logic               re;
    logic [TEXEL_W-1:0] addr;
  } mem_req_t;

endpackage

>>> hdl/ttsd_ar_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttsd_ar_mem
// Alpha-red store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ttsd_ar_mem
  import ttsd_pkg::*;
(
  input  logic              clk_i,
  input  mem_req_t          req_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [TEXELS_PER_TILE];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/ttsd_tile_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttsd_tile_walk
// Configuration registers and the tile walk: word position, tile column and
// row, pixel coordinates and store addressing for each incoming word.
// ----------------------------------------------------------------------------
module ttsd_tile_walk
  import ttsd_pkg::*;
#(
  parameter int unsigned MAX_DIMENSION = MAX_DIM_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 word_fire_i,
  output pix_info_t            pix_o,
  output mem_req_t             mem_req_o
);

  localparam int unsigned MaxTiles = (MAX_DIMENSION + TILE_SIDE - 1) / TILE_SIDE;
  localparam int unsigned TileW    = (MaxTiles > 1) ? $clog2(MaxTiles) : 1;
  localparam int unsigned CmpW     = ((TileW + TILE_BITS > CFG_W) ? TileW + TILE_BITS
                                                                  : CFG_W) + 1;

  logic [1:0]            fmt_q;
  logic [CFG_W-1:0]      width_q, height_q;
  logic [WORD_POS_W-1:0] word_q, word_d;
  logic [TileW-1:0]      tcol_q, tcol_d, trow_q, trow_d;

  logic [CFG_W-1:0]      w_clamp, h_clamp;
  logic [CmpW-1:0]       w_ext, h_ext, x_full, y_full, x_edge, y_edge;
  logic [TEXEL_W-1:0]    texel;
  logic                  planes, is_ar, in_image, tile_end, col_end, row_end;
  logic                  cfg_hit;

  // out-of-range dimensions are pulled into 1..MAX_DIMENSION
  always_comb begin
    w_clamp = width_q;
    if (width_q == '0) begin
      w_clamp = CFG_W'(1);
    end else if (32'(width_q) > MAX_DIMENSION) begin
      w_clamp = CFG_W'(MAX_DIMENSION);
    end
    h_clamp = height_q;
    if (height_q == '0) begin
      h_clamp = CFG_W'(1);
    end else if (32'(height_q) > MAX_DIMENSION) begin
      h_clamp = CFG_W'(MAX_DIMENSION);
    end
  end

  assign planes = (fmt_q == FMT_RGBA8);
  assign texel  = word_q[TEXEL_W-1:0];
  assign is_ar  = planes && !word_q[TEXEL_W];

  assign w_ext  = CmpW'(w_clamp);
  assign h_ext  = CmpW'(h_clamp);
  assign x_full = CmpW'({tcol_q, texel[TILE_BITS-1:0]});
  assign y_full = CmpW'({trow_q, texel[TEXEL_W-1:TILE_BITS]});
  // one past the right and bottom edge of the current tile
  assign x_edge = CmpW'({tcol_q, {TILE_BITS{1'b1}}}) + CmpW'(1);
  assign y_edge = CmpW'({trow_q, {TILE_BITS{1'b1}}}) + CmpW'(1);

  assign in_image = (x_full < w_ext) && (y_full < h_ext);
  assign col_end  = (x_edge >= w_ext);
  assign row_end  = (y_edge >= h_ext);
  assign tile_end = planes ? (word_q == {WORD_POS_W{1'b1}})
                           : (word_q >= WORD_POS_W'(TEXELS_PER_TILE - 1));

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FORMAT, REG_WIDTH, REG_HEIGHT: cfg_hit = 1'b1;
        default:                           cfg_hit = 1'b0;
      endcase
    end
  end

  always_comb begin
    word_d = word_q;
    tcol_d = tcol_q;
    trow_d = trow_q;
    if (cfg_hit) begin
      word_d = '0;
      tcol_d = '0;
      trow_d = '0;
    end else if (word_fire_i) begin
      if (tile_end) begin
        word_d = '0;
        if (col_end) begin
          tcol_d = '0;
          trow_d = row_end ? '0 : trow_q + TileW'(1);
        end else begin
          tcol_d = tcol_q + TileW'(1);
        end
      end else begin
        word_d = word_q + WORD_POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_RGB565;
      width_q  <= CFG_W'(1);
      height_q <= CFG_W'(1);
      word_q   <= '0;
      tcol_q   <= '0;
      trow_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FORMAT: fmt_q    <= cfg_data_i[1:0];
          REG_WIDTH:  width_q  <= cfg_data_i;
          REG_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      word_q <= word_d;
      tcol_q <= tcol_d;
      trow_q <= trow_d;
    end
  end

  assign pix_o.emit    = !is_ar && in_image;
  assign pix_o.planes  = planes;
  assign pix_o.fmt_5a3 = (fmt_q == FMT_RGB5A3);
  assign pix_o.x       = x_full[COORD_W-1:0];
  assign pix_o.y       = y_full[COORD_W-1:0];
  assign pix_o.last    = (x_full + CmpW'(1) == w_ext) && (y_full + CmpW'(1) == h_ext);

  assign mem_req_o.we   = word_fire_i && is_ar;
  assign mem_req_o.re   = word_fire_i && planes && word_q[TEXEL_W];
  assign mem_req_o.addr = texel;

`ifndef NO_ASSERTIONS
  // green-blue half of the tile only exists for the rgba8 planes
  a_word_pos_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fmt_q != FMT_RGBA8) |-> !word_q[TEXEL_W])
    else $error("word position in second half outside rgba8");

  a_mem_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req_o.we && mem_req_o.re))
    else $error("alpha-red store read and written in one cycle");
`endif

endmodule

>>> hdl/ttsd_texel_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttsd_texel_out
// Colour expansion stage and output register with the output handshake.
// ----------------------------------------------------------------------------
module ttsd_texel_out
  import ttsd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  word_fire_i,
  output logic                  word_ready_o,
  input  pix_info_t             pix_i,
  input  logic [DATA_W-1:0]     word_i,
  input  logic [DATA_W-1:0]     ar_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic                  out_last_o
);

  function automatic logic [COLOR_W-1:0] grow5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  function automatic logic [COLOR_W-1:0] grow6(input logic [5:0] c);
    return {c, c[5:4]};
  endfunction

  function automatic logic [COLOR_W-1:0] grow4(input logic [3:0] c);
    return {c, c};
  endfunction

  function automatic logic [COLOR_W-1:0] grow3(input logic [2:0] a);
    return {a, a, a[2:1]};
  endfunction

  logic                s1_valid_q, s1_valid_d;
  pix_info_t           s1_pix_q;
  logic [DATA_W-1:0]   s1_word_q;
  logic                out_valid_q, out_valid_d;
  logic                out_load, s1_ready;
  logic [COLOR_W-1:0]  red, green, blue, alpha;
  logic [COLOR_W-1:0]  red_q, green_q, blue_q, alpha_q;
  logic [COORD_W-1:0]  x_q, y_q;
  logic                last_q;

  assign out_load     = !out_valid_q || out_ready_i;
  assign s1_ready     = !s1_valid_q || out_load;
  assign word_ready_o = s1_ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_ready) begin
      s1_valid_d = word_fire_i && pix_i.emit;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = s1_valid_q;
    end
  end

  // ar_i is the store entry read when this word was taken
  always_comb begin
    red   = grow5(s1_word_q[15:11]);
    green = grow6(s1_word_q[10:5]);
    blue  = grow5(s1_word_q[4:0]);
    alpha = '1;
    if (s1_pix_q.planes) begin
      red   = ar_i[7:0];
      alpha = ar_i[15:8];
      green = s1_word_q[15:8];
      blue  = s1_word_q[7:0];
    end else if (s1_pix_q.fmt_5a3) begin
      if (s1_word_q[15]) begin
        red   = grow5(s1_word_q[14:10]);
        green = grow5(s1_word_q[9:5]);
        blue  = grow5(s1_word_q[4:0]);
      end else begin
        alpha = grow3(s1_word_q[14:12]);
        red   = grow4(s1_word_q[11:8]);
        green = grow4(s1_word_q[7:4]);
        blue  = grow4(s1_word_q[3:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && word_fire_i) begin
      s1_pix_q  <= pix_i;
      s1_word_q <= word_i;
    end
    if (out_load && s1_valid_q) begin
      x_q     <= s1_pix_q.x;
      y_q     <= s1_pix_q.y;
      last_q  <= s1_pix_q.last;
      red_q   <= red;
      green_q <= green;
      blue_q  <= blue;
      alpha_q <= alpha;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_last_o  = last_q;
  assign out_data_o  = {4'b0, alpha_q, blue_q, green_q, red_q, y_q, x_q};

`ifndef NO_ASSERTIONS
  // a held texel in the colour stage is never dropped
  a_s1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_load) |=> s1_valid_q)
    else $error("colour stage lost a texel while stalled");
`endif

endmodule

>>> hdl/tiled_texture_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiled_texture_stream_decoder
// Decodes a stream of 16-bit words of 4x4 tiled rgb565, rgb5a3 or rgba8
// texture data into one coordinate and rgba8 colour request per image pixel.
//
// channel   direction  fields (low bits first)
// s_axis    in         tdata: data_word
// m_axis    out        tdata: pixel_x, pixel_y, red, green, blue, alpha; tlast: last_pixel
// cfg       in         cfg_idx_i: 0 format, 1 width, 2 height; cfg_data_i: value
//
// one word accepted per cycle while s_axis_tready is high; a pixel passes the
// colour stage and output registers; the walk counters sit in flops, the rgba8
// alpha-red words in a 16 x 16 store read as the matching green-blue word is taken
// reset clears counters, configuration and valid flags at once; the store needs
// no clearing; an output stall backs up through the colour stage to s_axis_tready
// ----------------------------------------------------------------------------
module tiled_texture_stream_decoder
  import ttsd_pkg::*;
#(
  parameter int unsigned MAX_DIMENSION = MAX_DIM_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [DATA_W-1:0]     s_axis_tdata,   // data_word
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // pixel_x, pixel_y, red, green, blue, alpha
  output logic                  m_axis_tlast
);

  logic              word_fire;
  pix_info_t         pix;
  mem_req_t          mem_req;
  logic [DATA_W-1:0] ar_rdata;

  assign word_fire = s_axis_tvalid && s_axis_tready;

  ttsd_tile_walk #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .word_fire_i(word_fire),
    .pix_o      (pix),
    .mem_req_o  (mem_req)
  );

  ttsd_ar_mem u_ar_mem (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .wdata_i(s_axis_tdata),
    .rdata_o(ar_rdata)
  );

  ttsd_texel_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_fire_i (word_fire),
    .word_ready_o(s_axis_tready),
    .pix_i       (pix),
    .word_i      (s_axis_tdata),
    .ar_i        (ar_rdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tiled texture stream decoder. Texture words go
// in through a queue-fed driver; a built-in tile walker predicts each
// accepted word's pixel, and a monitor compares every pixel request field by
// field, across all formats, clamped sizes and random back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import ttsd_pkg::*;

  localparam logic [1:0]           FMT_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;
  localparam int unsigned          MAX_SIDE   = 1024;
  localparam int unsigned          SETTLE     = 6;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
    logic [COLOR_W-1:0] a;
    logic               last;
  } pixel_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_W-1:0]      cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [DATA_W-1:0]     s_axis_tdata  = '0;   // data_word
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // pixel_x, pixel_y, red, green, blue, alpha
  logic                  m_axis_tlast;         // last_pixel

  logic [DATA_W-1:0] texture_words[$];
  pixel_t            expected_pixels[$];
  int unsigned       mismatches   = 0;
  int unsigned       words_queued = 0;
  int unsigned       tx_idle_pct  = 30;
  int unsigned       rx_idle_pct  = 51;
  logic              tx_hold      = 1'b0;
  int unsigned       stall_req    = 0;
  int unsigned       stall_seen   = 0;
  int unsigned       stall_left   = 0;

  // decoder state as the bench sees it
  logic [1:0]   fmt_q;
  logic [10:0]  width_q;
  logic [10:0]  height_q;
  logic [4:0]   word_pos;
  logic [7:0]   tile_col;
  logic [7:0]   tile_row;
  logic [15:0]  alpha_red_words [TEXELS_PER_TILE];

  tiled_texture_stream_decoder u_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned clamp_dim(logic [10:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return 32'(v);
  endfunction

  function automatic void decode_texel_word(logic [15:0] v);
    int unsigned w, h, across, down, words_per_tile, x, y;
    logic [3:0]  texel;
    logic        has_texel;
    pixel_t      px;
    w              = clamp_dim(width_q);
    h              = clamp_dim(height_q);
    across         = (w + 3) / 4;
    down           = (h + 3) / 4;
    words_per_tile = (fmt_q == FMT_RGBA8) ? 32 : 16;
    texel          = word_pos[3:0];
    has_texel      = 1'b1;
    px             = '0;
    if (fmt_q == FMT_RGBA8) begin
      if (!word_pos[4]) begin
        alpha_red_words[texel] = v;
        has_texel = 1'b0;
      end else begin
        px.r = alpha_red_words[texel][7:0];
        px.a = alpha_red_words[texel][15:8];
        px.g = v[15:8];
        px.b = v[7:0];
      end
    end else if (fmt_q == FMT_RGB5A3) begin
      if (v[15]) begin
        px.r = {v[14:10], v[14:12]};
        px.g = {v[9:5], v[9:7]};
        px.b = {v[4:0], v[4:2]};
        px.a = 8'hFF;
      end else begin
        px.a = {v[14:12], v[14:12], v[14:13]};
        px.r = {v[11:8], v[11:8]};
        px.g = {v[7:4], v[7:4]};
        px.b = {v[3:0], v[3:0]};
      end
    end else begin
      // the unused format code falls back to rgb565 too
      px.r = {v[15:11], v[15:13]};
      px.g = {v[10:5], v[10:9]};
      px.b = {v[4:0], v[4:2]};
      px.a = 8'hFF;
    end
    x = tile_col * 4 + texel[1:0];
    y = tile_row * 4 + texel[3:2];
    if (has_texel && x < w && y < h) begin
      px.x    = x[COORD_W-1:0];
      px.y    = y[COORD_W-1:0];
      px.last = (x == w - 1) && (y == h - 1);
      expected_pixels = {expected_pixels, px};
    end
    if (word_pos + 1 >= words_per_tile) begin
      word_pos = '0;
      if (tile_col + 1 >= across) begin
        tile_col = '0;
        if (tile_row + 1 >= down) tile_row = '0;
        else tile_row = tile_row + 8'd1;
      end else begin
        tile_col = tile_col + 8'd1;
      end
    end else begin
      word_pos = word_pos + 5'd1;
    end
  endfunction

  // walker: follows register writes and accepted words
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      fmt_q    = FMT_RGB565;
      width_q  = 11'd1;
      height_q = 11'd1;
      word_pos = '0;
      tile_col = '0;
      tile_row = '0;
    end else begin
      if (cfg_we_i && cfg_idx_i != REG_SPARE) begin
        case (cfg_idx_i)
          REG_FORMAT: fmt_q    = cfg_data_i[1:0];
          REG_WIDTH:  width_q  = cfg_data_i;
          REG_HEIGHT: height_q = cfg_data_i;
          default: ;
        endcase
        word_pos = '0;
        tile_col = '0;
        tile_row = '0;
      end
      if (s_axis_tvalid && s_axis_tready) decode_texel_word(s_axis_tdata);
    end
  end

  // word driver
  always @(posedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (texture_words.size() != 0 && !tx_hold &&
          $urandom_range(99) >= tx_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= texture_words.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // pixel receiver back-pressure, with one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_seen != stall_req) begin
      stall_seen    <= stall_req;
      stall_left    <= 300;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 200)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // pixel monitor
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 200)
          $display("%0t: unexpected pixel, expected none, got tdata %h tlast %b",
                   $time, m_axis_tdata, m_axis_tlast);
      end else begin
        want = expected_pixels.pop_front();
        check_field("pixel_x", want.x, m_axis_tdata[9:0]);
        check_field("pixel_y", want.y, m_axis_tdata[19:10]);
        check_field("red", want.r, m_axis_tdata[27:20]);
        check_field("green", want.g, m_axis_tdata[35:28]);
        check_field("blue", want.b, m_axis_tdata[43:36]);
        check_field("alpha", want.a, m_axis_tdata[51:44]);
        check_field("last_pixel", want.last, m_axis_tlast);
      end
    end
  end

  task automatic send_word(logic [15:0] v);
    while (texture_words.size() >= 4) @(posedge clk_i);
    texture_words = {texture_words, v};
    words_queued++;
    if (words_queued == 300) stall_req <= stall_req + 1;
    if (words_queued == 700) begin
      // sender holds back until the decoder has nothing left to deliver
      tx_hold <= 1'b1;
      @(posedge clk_i);
      while (s_axis_tvalid || expected_pixels.size() != 0) @(posedge clk_i);
      tx_hold <= 1'b0;
    end
  endtask

  // padding words and alpha-red words give no pixel, so a settling wait follows the drained queues
  task automatic quiesce();
    while (texture_words.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic set_image(logic [1:0] fmt, logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    quiesce();
    write_reg(REG_FORMAT, {9'($urandom_range(0, 511)), fmt});
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    if ($urandom_range(3) == 0) write_reg(REG_SPARE, 11'($urandom_range(0, 2047)));
  endtask

  function automatic logic [15:0] random_word();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] random_dim();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 11'($urandom_range(1025, 2047));
      2:       return 11'($urandom_range(17, 40));
      default: return 11'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic run_image(logic [1:0] fmt, logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                           int unsigned n);
    set_image(fmt, w, h);
    repeat (n) send_word(random_word());
  endtask

  initial begin
    int unsigned random_words;
    int unsigned img_words;
    int unsigned n;
    logic [1:0]  fmt;
    logic [10:0] w;
    logic [10:0] h;
    random_words = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: rgb565, one pixel image, only the first texel shows
    send_word(16'hFFFF);
    send_word(16'h0000);

    // rgb5a3 opaque and translucent texels, one row of four
    set_image(FMT_RGB5A3, 11'd4, 11'd1);
    send_word(16'h8000);
    send_word(16'hFFFF);
    send_word(16'h7FFF);
    send_word(16'h0000);
    send_word(16'h7000);
    send_word(16'h0FFF);
    send_word(16'h8421);
    send_word(16'h1234);

    // unused format code, zero width and oversized height
    set_image(FMT_UNUSED, 11'd0, 11'd2047);
    send_word(16'hF800);
    send_word(16'h07E0);
    send_word(16'h001F);
    // a write to the spare index must not restart the tile walk
    quiesce();
    write_reg(REG_SPARE, 11'h7FF);
    send_word(16'h0000);
    send_word(16'hFFFF);

    while (random_words < 900) begin
      if (random_words < 300) begin
        tx_idle_pct <= 30;
        rx_idle_pct <= 51;
      end else if (random_words < 600) begin
        tx_idle_pct <= 51;
        rx_idle_pct <= 30;
      end else begin
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
      end
      fmt = 2'($urandom_range(0, 3));
      if ($urandom_range(2) == 0) fmt = FMT_RGBA8;
      w = random_dim();
      h = random_dim();
      img_words = ((clamp_dim(w) + 3) / 4) * ((clamp_dim(h) + 3) / 4) *
                  ((fmt == FMT_RGBA8) ? 32 : 16);
      if (img_words <= 400 && $urandom_range(3) != 0)
        n = img_words * $urandom_range(1, 2);
      else
        n = $urandom_range(1, (img_words < 400) ? img_words : 400);
      if (n > 900 - random_words) n = 900 - random_words;
      run_image(fmt, w, h, n);
      random_words += n;
    end

    // widest and tallest images, each walked in part
    run_image(FMT_RGB565, 11'd1024, 11'd1, 64);
    run_image(FMT_RGBA8, 11'd2047, 11'd2047, 96);
    run_image(FMT_RGB5A3, 11'd1, 11'd1024, 48);

    quiesce();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
